// ===== src/kcl_pkg.sv =====
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants for the keyed concurrency limiter
// holds table sizing, status codes and the controller/datapath command bundle
// ----------------------------------------------------------------------------
`default_nettype none
package kcl_pkg;

    localparam int TableDepth  = 64;
    localparam int LimitBits   = 16;
    localparam int HandleBits  = 6;
    localparam int IdxBits     = $clog2(TableDepth);
    localparam int CountBits   = LimitBits + 1;
    localparam int RuleBits    = 32;
    localparam int DigestBits  = 64;

    localparam logic [CountBits-1:0] CountSat = CountBits'(1) << LimitBits;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVER = 2'd1,
        ST_FULL = 2'd2,
        ST_FREE = 2'd3
    } status_t;

    typedef struct packed {
        logic load;    // capture the input beat
        logic update;  // apply the table update and form the result
    } kcl_cmd_t;

    typedef struct packed {
        logic res_valid;
    } kcl_stat_t;

endpackage
`default_nettype wire

// ===== src/kcl_datapath.sv =====
// ----------------------------------------------------------------------------
// kcl_datapath: key table, parallel match and counter update
// captures one beat, matches it against all entries, then updates one entry
// ----------------------------------------------------------------------------
`default_nettype none
module kcl_datapath (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire kcl_pkg::kcl_cmd_t                    cmd,
    input  wire logic                                 in_mode,
    input  wire logic                                 in_scope,
    input  wire logic [kcl_pkg::RuleBits-1:0]         in_rule_id,
    input  wire logic [kcl_pkg::DigestBits-1:0]       in_sql_digest,
    input  wire logic [kcl_pkg::LimitBits-1:0]        in_limit,
    input  wire logic [kcl_pkg::HandleBits-1:0]       in_release_handle,
    output logic [1:0]                                out_status,
    output logic [kcl_pkg::HandleBits-1:0]            out_handle,
    output logic [kcl_pkg::CountBits-1:0]             out_holders
);
    localparam int D  = kcl_pkg::TableDepth;
    localparam int IB = kcl_pkg::IdxBits;
    localparam int CB = kcl_pkg::CountBits;

    logic [D-1:0]                     valid_reg;
    logic [D-1:0]                     escope_reg;
    logic [kcl_pkg::RuleBits-1:0]     erule_reg   [D];
    logic [kcl_pkg::DigestBits-1:0]   edigest_reg [D];
    logic [CB-1:0]                    ecount_reg  [D];
    logic [kcl_pkg::LimitBits-1:0]    elimit_reg  [D];

    logic                             mode_reg;
    logic                             scope_reg;
    logic [kcl_pkg::RuleBits-1:0]     rule_reg;
    logic [kcl_pkg::DigestBits-1:0]   digest_reg;
    logic [kcl_pkg::LimitBits-1:0]    limit_reg;
    logic [kcl_pkg::HandleBits-1:0]   rhandle_reg;

    logic [D-1:0] hit_vec;
    logic [D-1:0] free_vec;
    logic         hit_any;
    logic         free_any;
    logic [IB-1:0] hit_idx;
    logic [IB-1:0] free_idx;

    always_comb begin
        for (int i = 0; i < D; i++) begin
            hit_vec[i] = valid_reg[i] && escope_reg[i] == scope_reg &&
                         erule_reg[i] == rule_reg && edigest_reg[i] == digest_reg;
            free_vec[i] = !valid_reg[i];
        end
    end

    // lowest-index priority encoders
    always_comb begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = D - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_any = 1'b1;
                hit_idx = IB'(i);
            end
            if (free_vec[i]) begin
                free_any = 1'b1;
                free_idx = IB'(i);
            end
        end
    end

    logic          rel_in_range;
    logic [IB-1:0] rel_idx;
    logic [CB-1:0] cur_count;
    logic [CB-1:0] acq_count;
    logic [CB-1:0] rel_count;
    logic [kcl_pkg::LimitBits-1:0] acq_limit;

    assign rel_in_range = ({1'b0, rhandle_reg} < (kcl_pkg::HandleBits+1)'(D));
    assign rel_idx      = IB'(rhandle_reg);
    assign cur_count    = hit_any ? ecount_reg[hit_idx] : ecount_reg[rel_idx];
    assign acq_count    = !hit_any ? CB'(1)
                        : (cur_count < kcl_pkg::CountSat ? cur_count + CB'(1) : cur_count);
    assign acq_limit    = hit_any ? elimit_reg[hit_idx] : limit_reg;
    assign rel_count    = ecount_reg[rel_idx] != '0 ? ecount_reg[rel_idx] - CB'(1) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.update) begin
            if (mode_reg) begin
                if (rel_in_range && valid_reg[rel_idx] && rel_count == '0)
                    valid_reg[rel_idx] <= 1'b0;
            end else if (!hit_any && free_any) begin
                valid_reg[free_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg    <= in_mode;
            scope_reg   <= in_scope;
            rule_reg    <= in_rule_id;
            digest_reg  <= in_scope ? in_sql_digest : '0;
            limit_reg   <= in_limit;
            rhandle_reg <= in_release_handle;
        end
        if (cmd.update) begin
            if (mode_reg) begin
                if (rel_in_range && valid_reg[rel_idx]) begin
                    ecount_reg[rel_idx] <= rel_count;
                    out_status  <= kcl_pkg::ST_OK;
                    out_holders <= rel_count;
                end else begin
                    out_status  <= kcl_pkg::ST_FREE;
                    out_holders <= '0;
                end
                out_handle <= rhandle_reg;
            end else if (!hit_any && !free_any) begin
                out_status  <= kcl_pkg::ST_FULL;
                out_handle  <= '0;
                out_holders <= '0;
            end else begin
                if (hit_any) begin
                    ecount_reg[hit_idx] <= acq_count;
                end else begin
                    escope_reg[free_idx]  <= scope_reg;
                    erule_reg[free_idx]   <= rule_reg;
                    edigest_reg[free_idx] <= digest_reg;
                    ecount_reg[free_idx]  <= acq_count;
                    elimit_reg[free_idx]  <= limit_reg;
                end
                out_status  <= (acq_limit == '0 || acq_count > CB'(acq_limit))
                               ? kcl_pkg::ST_OVER : kcl_pkg::ST_OK;
                out_handle  <= kcl_pkg::HandleBits'(hit_any ? hit_idx : free_idx);
                out_holders <= acq_count;
            end
        end
    end
endmodule
`default_nettype wire

// ===== src/kcl_ctrl.sv =====
// ----------------------------------------------------------------------------
// kcl_ctrl: handshake controller for the keyed concurrency limiter
// sequences capture, table update and result delivery
// ----------------------------------------------------------------------------
`default_nettype none
module kcl_ctrl (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  wire logic         m_ready,
    output kcl_pkg::kcl_cmd_t cmd
);
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WORK = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;

    // a new beat may enter while a finished result waits, as long as the
    // result register frees before the update lands
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg;
        cmd.load    = 1'b0;
        cmd.update  = 1'b0;
        if (mvalid_reg && m_ready)
            mvalid_next = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_WORK;
                end
            end
            S_WORK: begin
                if (!mvalid_reg || m_ready) begin
                    cmd.update  = 1'b1;
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end
endmodule
`default_nettype wire

// ===== src/keyed_concurrency_limiter.sv =====
// ----------------------------------------------------------------------------
// keyed_concurrency_limiter: per-key counting semaphore table
// acquire by key or release by handle, one result beat per input beat
// ----------------------------------------------------------------------------
// Each beat is captured, then all 64 entries are compared in parallel and
// the single matching or lowest free counter (on release, the handle's
// entry) is read, updated and written back. A new beat is taken while the
// previous result still waits on m_ready; the update waits only if that
// result is still unclaimed. No clearing pass is needed after reset.
`default_nettype none
module keyed_concurrency_limiter (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_mode,
    input  wire logic                               s_scope,
    input  wire logic [kcl_pkg::RuleBits-1:0]       s_rule_id,
    input  wire logic [kcl_pkg::DigestBits-1:0]     s_sql_digest,
    input  wire logic [kcl_pkg::LimitBits-1:0]      s_limit,
    input  wire logic [kcl_pkg::HandleBits-1:0]     s_release_handle,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [1:0]                              m_status,
    output logic [kcl_pkg::HandleBits-1:0]          m_handle,
    output logic [kcl_pkg::CountBits-1:0]           m_holders
);
    kcl_pkg::kcl_cmd_t cmd;

    kcl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    kcl_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .in_mode           (s_mode),
        .in_scope          (s_scope),
        .in_rule_id        (s_rule_id),
        .in_sql_digest     (s_sql_digest),
        .in_limit          (s_limit),
        .in_release_handle (s_release_handle),
        .out_status        (m_status),
        .out_handle        (m_handle),
        .out_holders       (m_holders)
    );
endmodule
`default_nettype wire

// ===== dv/kcl_checker.sv =====
// ----------------------------------------------------------------------------
// kcl_checker: result checker for the keyed concurrency limiter
// mirrors the semaphore table from accepted input beats and compares every
// result beat, in order, against the predicted status, handle and holders
// ----------------------------------------------------------------------------
module kcl_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           s_mode,
    input  logic                           s_scope,
    input  logic [kcl_pkg::RuleBits-1:0]   s_rule_id,
    input  logic [kcl_pkg::DigestBits-1:0] s_sql_digest,
    input  logic [kcl_pkg::LimitBits-1:0]  s_limit,
    input  logic [kcl_pkg::HandleBits-1:0] s_release_handle,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [1:0]                     m_status,
    input  logic [kcl_pkg::HandleBits-1:0] m_handle,
    input  logic [kcl_pkg::CountBits-1:0]  m_holders,
    output int                             fail_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        kcl_pkg::status_t               status;
        logic [kcl_pkg::HandleBits-1:0] handle;
        logic [kcl_pkg::CountBits-1:0]  holders;
    } verdict_t;

    verdict_t verdict_q[$];

    logic                           slot_used   [kcl_pkg::TableDepth];
    logic                           slot_scope  [kcl_pkg::TableDepth];
    logic [kcl_pkg::RuleBits-1:0]   slot_rule   [kcl_pkg::TableDepth];
    logic [kcl_pkg::DigestBits-1:0] slot_digest [kcl_pkg::TableDepth];
    logic [kcl_pkg::CountBits-1:0]  slot_count  [kcl_pkg::TableDepth];
    logic [kcl_pkg::LimitBits-1:0]  slot_limit  [kcl_pkg::TableDepth];

    initial pending = 0;

    function automatic verdict_t grant_or_release(logic mode, logic scope,
            logic [kcl_pkg::RuleBits-1:0] rule, logic [kcl_pkg::DigestBits-1:0] digest,
            logic [kcl_pkg::LimitBits-1:0] lim, logic [kcl_pkg::HandleBits-1:0] h);
        verdict_t v;
        int hit;
        int spare;
        logic [kcl_pkg::DigestBits-1:0] key_digest;
        hit = -1;
        spare = -1;
        key_digest = scope ? digest : '0;
        if (mode) begin
            v.handle = h;
            if (!slot_used[h]) begin
                v.status = kcl_pkg::ST_FREE;
                v.holders = '0;
                return v;
            end
            if (slot_count[h] != 0) slot_count[h]--;
            if (slot_count[h] == 0) slot_used[h] = 1'b0;
            v.status = kcl_pkg::ST_OK;
            v.holders = slot_count[h];
            return v;
        end
        for (int i = 0; i < kcl_pkg::TableDepth; i++) begin
            if (slot_used[i]) begin
                if (hit < 0 && slot_scope[i] == scope && slot_rule[i] == rule &&
                    slot_digest[i] == key_digest) hit = i;
            end else if (spare < 0) begin
                spare = i;
            end
        end
        if (hit < 0) begin
            if (spare < 0) begin
                v.status = kcl_pkg::ST_FULL;
                v.handle = '0;
                v.holders = '0;
                return v;
            end
            hit = spare;
            slot_used[hit] = 1'b1;
            slot_scope[hit] = scope;
            slot_rule[hit] = rule;
            slot_digest[hit] = key_digest;
            slot_count[hit] = kcl_pkg::CountBits'(1);
            slot_limit[hit] = lim;
        end else if (slot_count[hit] < kcl_pkg::CountSat) begin
            slot_count[hit]++;
        end
        v.handle = hit[kcl_pkg::HandleBits-1:0];
        v.holders = slot_count[hit];
        v.status = (slot_limit[hit] == 0 ||
                    slot_count[hit] > kcl_pkg::CountBits'(slot_limit[hit]))
                   ? kcl_pkg::ST_OVER : kcl_pkg::ST_OK;
        return v;
    endfunction

    function automatic void queue_verdict(verdict_t v);
        verdict_q.insert(verdict_q.size(), v);
    endfunction

    always @(posedge aclk) begin
        verdict_t exp_v;
        if (!aresetn) begin
            for (int i = 0; i < kcl_pkg::TableDepth; i++) slot_used[i] = 1'b0;
            verdict_q.delete();
            fail_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result beat status=%0d handle=%0d holders=%0d",
                             $time, m_status, m_handle, m_holders);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (m_status !== exp_v.status || m_handle !== exp_v.handle ||
                        m_holders !== exp_v.holders) begin
                        $display({"%0t: mismatch expected status=%0d handle=%0d holders=%0d",
                                  " actual status=%0d handle=%0d holders=%0d"},
                                 $time, exp_v.status, exp_v.handle, exp_v.holders,
                                 m_status, m_handle, m_holders);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready)
                queue_verdict(grant_or_release(s_mode, s_scope, s_rule_id,
                    s_sql_digest, s_limit, s_release_handle));
        end
        pending <= verdict_q.size();
    end
endmodule

// ===== dv/keyed_concurrency_limiter_tb.sv =====
// ----------------------------------------------------------------------------
// keyed_concurrency_limiter_tb: stimulus and verdict for the limiter
// directed corner beats, then random acquire/release traffic over a small key
// pool with random gaps, stalls and one long output hold-off
// ----------------------------------------------------------------------------
module keyed_concurrency_limiter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic                           s_mode = 1'b0;
    logic                           s_scope = 1'b0;
    logic [kcl_pkg::RuleBits-1:0]   s_rule_id = '0;
    logic [kcl_pkg::DigestBits-1:0] s_sql_digest = '0;
    logic [kcl_pkg::LimitBits-1:0]  s_limit = '0;
    logic [kcl_pkg::HandleBits-1:0] s_release_handle = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [1:0]                     m_status;
    logic [kcl_pkg::HandleBits-1:0] m_handle;
    logic [kcl_pkg::CountBits-1:0]  m_holders;
    int                             fail_count;
    int                             pending;
    bit                             sending_done = 1'b0;
    bit                             hold_off = 1'b0;

    // key pool of rules and digests for the random acquires
    logic [kcl_pkg::RuleBits-1:0]   key_rule [8];
    logic [kcl_pkg::DigestBits-1:0] key_digest [8];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    keyed_concurrency_limiter u_dut (.*);

    kcl_checker u_chk (.*);

    function automatic int short_or_long_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(5, 30);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    task automatic send_beat(logic mode, logic scope, logic [kcl_pkg::RuleBits-1:0] rule,
            logic [kcl_pkg::DigestBits-1:0] digest, logic [kcl_pkg::LimitBits-1:0] lim,
            logic [kcl_pkg::HandleBits-1:0] h, bit use_gap);
        int gap;
        gap = use_gap ? short_or_long_gap() : 0;
        // the previous beat is already taken, so drop valid over the gap
        if (gap != 0) s_valid <= 1'b0;
        repeat (gap) @(posedge aclk);
        s_valid <= 1'b1;
        s_mode <= mode;
        s_scope <= scope;
        s_rule_id <= rule;
        s_sql_digest <= digest;
        s_limit <= lim;
        s_release_handle <= h;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (use_gap && $urandom_range(0, 3) != 0) s_valid <= 1'b0;
    endtask

    task automatic acquire(logic scope, logic [kcl_pkg::RuleBits-1:0] rule,
            logic [kcl_pkg::DigestBits-1:0] digest, logic [kcl_pkg::LimitBits-1:0] lim,
            bit use_gap);
        send_beat(1'b0, scope, rule, digest, lim, 6'($urandom), use_gap);
    endtask

    task automatic release_slot(logic [kcl_pkg::HandleBits-1:0] h, bit use_gap);
        send_beat(1'b1, 1'($urandom), $urandom, {$urandom, $urandom}, 16'($urandom),
                  h, use_gap);
    endtask

    // receiver: random stalls, plus one long hold-off when asked
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            stall = $urandom_range(0, 4) == 0 ? short_or_long_gap() : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    initial begin
        int k;
        int sel;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, limit zero, digest ignored at rule level
        acquire(1'b0, '0, '0, '0, 1'b0);
        acquire(1'b0, '0, '1, 16'd5, 1'b0);
        acquire(1'b0, '1, '1, '1, 1'b0);
        acquire(1'b1, '1, '1, 16'd1, 1'b0);
        acquire(1'b1, '1, '1, 16'd1, 1'b0);
        acquire(1'b1, '1, '0, 16'd2, 1'b0);
        acquire(1'b1, 32'h5a5a_a5a5, 64'ha5a5_5a5a_f00f_0ff0, 16'h8000, 1'b0);
        release_slot(6'd0, 1'b0);
        release_slot(6'd0, 1'b0);
        release_slot(6'd0, 1'b0);
        release_slot(6'd63, 1'b0);
        release_slot(6'd3, 1'b0);
        release_slot(6'd3, 1'b0);
        release_slot(6'd3, 1'b0);
        // fill the table, then the remaining keys see table full
        for (int i = 0; i < kcl_pkg::TableDepth + 2; i++)
            acquire(1'b1, 32'hc000_0000 + i, 64'(i), 16'd3, 1'b0);
        for (int i = 0; i < kcl_pkg::TableDepth; i++) release_slot(6'(i), 1'b0);
        for (int i = 0; i < kcl_pkg::TableDepth; i++) release_slot(6'(i), 1'b0);

        for (int i = 0; i < 8; i++) begin
            key_rule[i] = $urandom;
            key_digest[i] = {$urandom, $urandom};
        end

        // random: mostly a small key pool so counts climb and fall; long hold-off midway
        for (int n = 0; n < 740; n++) begin
            if (n == 300) hold_off = 1'b1;
            sel = $urandom_range(0, 9);
            k = $urandom_range(0, 7);
            if (sel < 5)
                acquire(1'($urandom), key_rule[k], key_digest[k] ^ 64'($urandom_range(0, 1)),
                        16'($urandom_range(0, 4)), 1'b1);
            else if (sel < 6)
                acquire(1'($urandom), $urandom, {$urandom, $urandom}, 16'($urandom), 1'b1);
            else if (sel < 9)
                release_slot(6'($urandom_range(0, 15)), 1'b1);
            else
                release_slot(6'($urandom), 1'b1);
        end
        s_valid <= 1'b0;
        sending_done = 1'b1;
    end

    initial begin
        wait (sending_done);
        wait (pending == 0);
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #2ms;
        $display("tb: failure");
        $finish;
    end
endmodule

// ===== files.f =====
src/kcl_pkg.sv
src/kcl_datapath.sv
src/kcl_ctrl.sv
src/keyed_concurrency_limiter.sv
dv/kcl_checker.sv
dv/keyed_concurrency_limiter_tb.sv
